// ===== src/sqme_pkg.sv =====
// ----------------------------------------------------------------------------
// Shift queue with mean events: shared package
// Codes, widths, reset values and the control type passed to the queue cells.
// ----------------------------------------------------------------------------
package sqme_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int LIMIT_W    = 31;
  localparam int WINDOW_LEN = 5;
  localparam int WSUM_W     = 35;
  localparam int WLIM_W     = 34;

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;

  localparam logic [1:0] ST_EMPTY = 2'd0;
  localparam logic [1:0] ST_OK    = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_MISS = 2'd1;
  localparam logic [1:0] EV_MET  = 2'd2;

  localparam logic [1:0] REG_FULL_LIMIT = 2'd0;
  localparam logic [1:0] REG_WIN_LOW    = 2'd1;
  localparam logic [1:0] REG_WIN_HIGH   = 2'd2;

  localparam logic [LIMIT_W-1:0] FULL_LIMIT_RST = 31'd65536;
  localparam logic [LIMIT_W-1:0] WIN_LOW_RST    = 31'd327680;
  localparam logic [LIMIT_W-1:0] WIN_HIGH_RST   = 31'd655360;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctl_t;

endpackage

// ===== src/sqme_item_if.sv =====
// ----------------------------------------------------------------------------
// Shift queue with mean events: item channel
// Valid/ready channel carrying one queue operation and its sample.
// ----------------------------------------------------------------------------
interface sqme_item_if;

  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           operation;
  logic signed [sqme_pkg::SAMPLE_W-1:0] sample_in;

  modport source (output valid, output operation, output sample_in, input ready);
  modport sink (input valid, input operation, input sample_in, output ready);

endinterface

// ===== src/sqme_result_if.sv =====
// ----------------------------------------------------------------------------
// Shift queue with mean events: result channel
// Valid/ready channel carrying the read sample, status, count and event codes.
// ----------------------------------------------------------------------------
interface sqme_result_if;

  logic                                 valid;
  logic                                 ready;
  logic signed [sqme_pkg::SAMPLE_W-1:0] sample_out;
  logic [1:0]                           queue_state;
  logic [4:0]                           entry_count;
  logic [1:0]                           full_mean_event;
  logic [1:0]                           window_low_event;
  logic [1:0]                           window_high_event;

  modport source (
    output valid, output sample_out, output queue_state, output entry_count,
    output full_mean_event, output window_low_event, output window_high_event,
    input ready
  );
  modport sink (
    input valid, input sample_out, input queue_state, input entry_count,
    input full_mean_event, input window_low_event, input window_high_event,
    output ready
  );

endinterface

// ===== src/sqme_cell.sv =====
// ----------------------------------------------------------------------------
// Shift queue with mean events: queue cell
// One sample of the queue; loads on a push aimed at its slot and takes its
// right-hand neighbour's sample on a pop.
// ----------------------------------------------------------------------------
module sqme_cell #(
  parameter int COUNT_W = 5,
  parameter int INDEX   = 0
) (
  input  logic                                 clk,
  input  sqme_pkg::cell_ctl_t                  ctl,
  input  logic [COUNT_W-1:0]                   count,
  input  logic signed [sqme_pkg::SAMPLE_W-1:0] value,
  input  logic signed [sqme_pkg::SAMPLE_W-1:0] nbr,
  output logic signed [sqme_pkg::SAMPLE_W-1:0] data
);

  logic hit;

  assign hit = (count == COUNT_W'(INDEX));

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      data <= nbr;
    end else if (ctl.push && hit) begin
      data <= value;
    end
  end

endmodule

// ===== src/shift_queue_with_mean_events_unit.sv =====
// ----------------------------------------------------------------------------
// Shift queue with mean events
// Shift-left queue of signed Q15.16 samples with threshold events on the mean
// magnitude of the whole queue and of its newest five entries.
//
// Items arrive on sample_ch: operation push, pop or peek with a sample. Each
// item gives exactly one transfer on result_ch with the sample read, the queue
// status, the entry count and three event codes taken after the item.
// Limits are to be written on cfg_we/cfg_index/cfg_data while the block is
// idle; the block itself does not enforce this. The two window limits are
// kept pre-scaled by five and the full limit by the depth, so the events need
// only an absolute value and a compare. Each result passes through the event
// stage into the output register. One item per cycle is sustained while the
// receiver keeps up: the queue cells, the running total and the newest-five sum
// all update on the transfer, and the event stage reads them when its item moves.
// When the receiver stalls, the event stage and output register fill and
// sample_ch.ready drops until the result is taken. Reset empties the queue,
// clears the sums and loads the default limits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module shift_queue_with_mean_events_unit #(
  parameter int DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  sqme_item_if.sink                         sample_ch,
  sqme_result_if.source                     result_ch,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [sqme_pkg::LIMIT_W-1:0]      cfg_data
);

  localparam int COUNT_W = $clog2(DEPTH + 1);
  localparam int TOTAL_W = sqme_pkg::SAMPLE_W + COUNT_W;
  localparam int FLIM_W  = sqme_pkg::LIMIT_W + COUNT_W;
  localparam int SW      = sqme_pkg::SAMPLE_W;

  logic signed [SW-1:0]                cells [DEPTH];
  logic signed [SW-1:0]                win [sqme_pkg::WINDOW_LEN];
  sqme_pkg::cell_ctl_t                 ctl;

  logic [COUNT_W-1:0]                  count, count_next;
  logic [1:0]                          status, status_next;
  logic signed [TOTAL_W-1:0]           total, total_next;
  logic signed [sqme_pkg::WSUM_W-1:0]  wsum, wsum_next;
  logic [FLIM_W-1:0]                   full_lim;
  logic [sqme_pkg::WLIM_W-1:0]         low_lim, high_lim;

  logic                                eval_valid;
  logic signed [SW-1:0]                eval_sample;
  logic signed [SW-1:0]                read_next;

  logic                                accept, move, is_empty, is_full, win_full;
  logic                                do_push, do_pop;
  logic [TOTAL_W-1:0]                  total_mag;
  logic [sqme_pkg::WSUM_W-1:0]         wsum_mag;

  assign accept   = sample_ch.valid && sample_ch.ready;
  assign is_empty = (count == '0);
  assign is_full  = (count == COUNT_W'(DEPTH));
  assign win_full = (count >= COUNT_W'(sqme_pkg::WINDOW_LEN));
  assign do_push  = accept && (sample_ch.operation == sqme_pkg::OP_PUSH) && !is_full;
  assign do_pop   = accept && (sample_ch.operation == sqme_pkg::OP_POP) && !is_empty;
  assign ctl.push = do_push;
  assign ctl.pop  = do_pop;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      sqme_cell #(
        .COUNT_W (COUNT_W),
        .INDEX   (gi)
      ) u_cell (
        .clk   (clk),
        .ctl   (ctl),
        .count (count),
        .value (sample_ch.sample_in),
        .nbr   (cells[(gi + 1 < DEPTH) ? gi + 1 : gi]),
        .data  (cells[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (do_push) begin
      win[0] <= sample_ch.sample_in;
      for (int i = 1; i < sqme_pkg::WINDOW_LEN; i++) begin
        win[i] <= win[i-1];
      end
    end
  end

  always_comb begin
    count_next  = count;
    status_next = status;
    read_next   = '0;
    total_next  = total;
    wsum_next   = wsum;
    if (accept) begin
      case (sample_ch.operation)
        sqme_pkg::OP_PUSH: begin
          if (is_full) begin
            status_next = sqme_pkg::ST_FULL;
          end else begin
            count_next  = count + 1'b1;
            status_next = (count_next == COUNT_W'(DEPTH)) ? sqme_pkg::ST_FULL
                                                          : sqme_pkg::ST_OK;
            total_next  = total + TOTAL_W'(sample_ch.sample_in);
            wsum_next   = wsum + sqme_pkg::WSUM_W'(sample_ch.sample_in);
            if (win_full) begin
              wsum_next = wsum_next - sqme_pkg::WSUM_W'(win[sqme_pkg::WINDOW_LEN-1]);
            end
          end
        end
        sqme_pkg::OP_POP: begin
          if (is_empty) begin
            status_next = sqme_pkg::ST_EMPTY;
          end else begin
            read_next   = cells[0];
            count_next  = count - 1'b1;
            status_next = (count_next == '0) ? sqme_pkg::ST_EMPTY : sqme_pkg::ST_OK;
            total_next  = total - TOTAL_W'(cells[0]);
            if (count <= COUNT_W'(sqme_pkg::WINDOW_LEN)) begin
              wsum_next = wsum - sqme_pkg::WSUM_W'(cells[0]);
            end
          end
        end
        sqme_pkg::OP_PEEK: begin
          if (is_empty) begin
            status_next = sqme_pkg::ST_EMPTY;
          end else begin
            read_next = cells[0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      status <= sqme_pkg::ST_EMPTY;
      total  <= '0;
      wsum   <= '0;
    end else begin
      count  <= count_next;
      status <= status_next;
      total  <= total_next;
      wsum   <= wsum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full_lim <= FLIM_W'(sqme_pkg::FULL_LIMIT_RST) * FLIM_W'(DEPTH);
      low_lim  <= sqme_pkg::WLIM_W'(sqme_pkg::WIN_LOW_RST) *
                  sqme_pkg::WLIM_W'(sqme_pkg::WINDOW_LEN);
      high_lim <= sqme_pkg::WLIM_W'(sqme_pkg::WIN_HIGH_RST) *
                  sqme_pkg::WLIM_W'(sqme_pkg::WINDOW_LEN);
    end else if (cfg_we) begin
      case (cfg_index)
        sqme_pkg::REG_FULL_LIMIT: full_lim <= FLIM_W'(cfg_data) * FLIM_W'(DEPTH);
        sqme_pkg::REG_WIN_LOW:    low_lim  <= sqme_pkg::WLIM_W'(cfg_data) *
                                              sqme_pkg::WLIM_W'(sqme_pkg::WINDOW_LEN);
        sqme_pkg::REG_WIN_HIGH:   high_lim <= sqme_pkg::WLIM_W'(cfg_data) *
                                              sqme_pkg::WLIM_W'(sqme_pkg::WINDOW_LEN);
        default: begin
        end
      endcase
    end
  end

  assign move            = eval_valid && (!result_ch.valid || result_ch.ready);
  assign sample_ch.ready = !eval_valid || move;

  always_ff @(posedge clk) begin
    if (rst) begin
      eval_valid <= 1'b0;
    end else if (accept) begin
      eval_valid <= 1'b1;
    end else if (move) begin
      eval_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      eval_sample <= read_next;
    end
  end

  assign total_mag = total[TOTAL_W-1] ? TOTAL_W'(-total) : TOTAL_W'(total);
  assign wsum_mag  = wsum[sqme_pkg::WSUM_W-1] ? sqme_pkg::WSUM_W'(-wsum)
                                              : sqme_pkg::WSUM_W'(wsum);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_ch.valid <= 1'b0;
    end else if (move) begin
      result_ch.valid <= 1'b1;
    end else if (result_ch.ready) begin
      result_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      result_ch.sample_out  <= eval_sample;
      result_ch.queue_state <= status;
      result_ch.entry_count <= 5'(count);
      if (is_full) begin
        result_ch.full_mean_event <= (total_mag <= TOTAL_W'(full_lim)) ?
                                     sqme_pkg::EV_MET : sqme_pkg::EV_MISS;
      end else begin
        result_ch.full_mean_event <= sqme_pkg::EV_NONE;
      end
      if (win_full) begin
        result_ch.window_low_event  <= (wsum_mag > sqme_pkg::WSUM_W'(low_lim)) ?
                                       sqme_pkg::EV_MET : sqme_pkg::EV_MISS;
        result_ch.window_high_event <= (wsum_mag > sqme_pkg::WSUM_W'(high_lim)) ?
                                       sqme_pkg::EV_MET : sqme_pkg::EV_MISS;
      end else begin
        result_ch.window_low_event  <= sqme_pkg::EV_NONE;
        result_ch.window_high_event <= sqme_pkg::EV_NONE;
      end
    end
  end

endmodule
